@@ rtl/core/grl_pkg.sv @@
// ----------------------------------------------------------------------------
// grl_pkg
// Shared types and constants of the glyph range lookup with LRU glyph cache.
// ----------------------------------------------------------------------------
`default_nettype none

package grl_pkg;

    localparam int RANGES      = 16;
    localparam int CACHE_SLOTS = 8;
    localparam int RANGE_W     = $clog2(RANGES);
    localparam int COUNT_W     = RANGE_W + 1;
    localparam int SLOT_W      = $clog2(CACHE_SLOTS);
    localparam int CP_W        = 21;
    localparam int ADDR_W      = 32;
    localparam int GB_W        = 6;
    localparam int AGE_W       = 32;
    localparam int PROD_W      = CP_W + GB_W;

    localparam int S_DATA_W = 112;
    localparam int M_DATA_W = 48;
    localparam int CFG_W    = 5;

    // configuration register indexes
    localparam logic REG_RANGE_COUNT = 1'b0;
    localparam logic REG_FONT_VALID  = 1'b1;

    // request kinds
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_CALC,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic match;
        logic calc;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic is_load;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/core/grl_ctrl.sv @@
// ----------------------------------------------------------------------------
// grl_ctrl
// Sequencer: capture a request, match ranges, compute (lookups only), commit the result.
// ----------------------------------------------------------------------------
`default_nettype none

module grl_ctrl
    import grl_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MATCH;
                end
            end
            ST_MATCH: begin
                cmd.match  = 1'b1;
                state_next = status.is_load ? ST_COMMIT : ST_CALC;
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                // hold until the output register is free
                if (!status.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/grl_datapath.sv @@
// ----------------------------------------------------------------------------
// grl_datapath
// Range table, glyph cache slots, address arithmetic and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module grl_datapath
    import grl_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cmd_t                cmd,
    output status_t                  status,
    input  wire logic                s_tuser,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata
);

    // configuration
    logic [COUNT_W-1:0] range_count_reg;
    logic               font_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_count_reg <= '0;
            font_valid_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_RANGE_COUNT: range_count_reg <= cfg_data[COUNT_W-1:0];
                REG_FONT_VALID:  font_valid_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // captured request
    logic               kind_reg;
    logic [RANGE_W-1:0] idx_reg;
    logic [CP_W-1:0]    first_reg, last_reg, cp_reg;
    logic [ADDR_W-1:0]  off_reg;
    logic [GB_W-1:0]    gb_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg  <= s_tuser;
            idx_reg   <= s_tdata[3:0];
            first_reg <= s_tdata[24:4];
            last_reg  <= s_tdata[45:25];
            off_reg   <= s_tdata[77:46];
            gb_reg    <= s_tdata[83:78];
            cp_reg    <= s_tdata[104:84];
        end
    end

    // range table, no reset
    logic [CP_W-1:0]   tbl_first [RANGES];
    logic [CP_W-1:0]   tbl_last  [RANGES];
    logic [ADDR_W-1:0] tbl_off   [RANGES];
    logic [GB_W-1:0]   tbl_bytes [RANGES];

    always_ff @(posedge aclk) begin
        if (cmd.commit && kind_reg == CMD_LOAD) begin
            tbl_first[idx_reg] <= first_reg;
            tbl_last[idx_reg]  <= last_reg;
            tbl_off[idx_reg]   <= off_reg;
            tbl_bytes[idx_reg] <= gb_reg;
        end
    end

    // cache slots
    logic [CP_W-1:0]  slot_cp_reg   [CACHE_SLOTS];
    logic             slot_full_reg [CACHE_SLOTS];
    logic [AGE_W-1:0] slot_age_reg  [CACHE_SLOTS];
    logic [AGE_W-1:0] age_reg;

    // match stage: first range in use that covers the codepoint
    logic [COUNT_W-1:0] used;
    logic               m_found;
    logic [RANGE_W-1:0] m_sel;
    logic [SLOT_W-1:0]  v_slot;
    logic [AGE_W-1:0]   v_old;
    logic               v_done;

    assign used = (range_count_reg > COUNT_W'(RANGES)) ? COUNT_W'(RANGES) : range_count_reg;

    always_comb begin
        m_found = 1'b0;
        m_sel   = '0;
        for (int i = RANGES - 1; i >= 0; i--) begin
            if (COUNT_W'(i) < used && cp_reg >= tbl_first[i] && cp_reg <= tbl_last[i]) begin
                m_found = 1'b1;
                m_sel   = RANGE_W'(i);
            end
        end
    end

    // victim: first empty slot, else oldest with lowest index
    always_comb begin
        v_slot = '0;
        v_old  = '1;
        v_done = 1'b0;
        for (int i = 0; i < CACHE_SLOTS; i++) begin
            if (!v_done) begin
                if (!slot_full_reg[i]) begin
                    v_slot = SLOT_W'(i);
                    v_done = 1'b1;
                end else if (slot_age_reg[i] < v_old) begin
                    v_old  = slot_age_reg[i];
                    v_slot = SLOT_W'(i);
                end
            end
        end
    end

    logic               found_reg;
    logic [RANGE_W-1:0] sel_reg;
    logic [SLOT_W-1:0]  victim_reg;

    always_ff @(posedge aclk) begin
        if (cmd.match) begin
            found_reg  <= m_found && font_valid_reg && kind_reg == CMD_LOOKUP;
            sel_reg    <= m_sel;
            victim_reg <= v_slot;
        end
    end

    // calc stage: product, hit search
    logic              h_hit;
    logic [SLOT_W-1:0] h_slot;

    always_comb begin
        h_hit  = 1'b0;
        h_slot = '0;
        for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
            if (slot_full_reg[i] && slot_cp_reg[i] == cp_reg) begin
                h_hit  = 1'b1;
                h_slot = SLOT_W'(i);
            end
        end
    end

    logic [PROD_W-1:0] prod_reg;
    logic [ADDR_W-1:0] roff_reg;
    logic [GB_W-1:0]   rbytes_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] hslot_reg;
    logic [CP_W-1:0]   diff;

    assign diff = cp_reg - tbl_first[sel_reg];

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            prod_reg   <= PROD_W'(diff) * PROD_W'(tbl_bytes[sel_reg]);
            roff_reg   <= tbl_off[sel_reg];
            rbytes_reg <= tbl_bytes[sel_reg];
            hit_reg    <= h_hit;
            hslot_reg  <= h_slot;
        end
    end

    // commit stage
    logic              do_upd;
    logic [SLOT_W-1:0] wslot;
    logic [AGE_W-1:0]  age_inc;
    logic [ADDR_W-1:0] addr;

    assign do_upd  = cmd.commit && found_reg && kind_reg == CMD_LOOKUP;
    assign wslot   = hit_reg ? hslot_reg : victim_reg;
    assign age_inc = age_reg + AGE_W'(1);
    assign addr    = roff_reg + ADDR_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_reg <= '0;
            for (int i = 0; i < CACHE_SLOTS; i++) begin
                slot_cp_reg[i]   <= '0;
                slot_full_reg[i] <= 1'b0;
                slot_age_reg[i]  <= '0;
            end
        end else if (do_upd) begin
            age_reg             <= age_inc;
            slot_age_reg[wslot] <= age_inc;
            if (!hit_reg) begin
                slot_cp_reg[wslot]   <= cp_reg;
                slot_full_reg[wslot] <= rbytes_reg != '0;
            end
        end
    end

    // output register
    logic                valid_reg;
    logic [M_DATA_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (do_upd) begin
                data_reg <= {5'd0, rbytes_reg, addr, wslot, hit_reg, 1'b1};
            end else begin
                data_reg <= '0;
            end
        end
    end

    assign m_tvalid        = valid_reg;
    assign m_tdata         = data_reg;
    assign status.is_load  = kind_reg == CMD_LOAD;
    assign status.out_busy = valid_reg && !m_tready;

endmodule

`default_nettype wire

@@ rtl/core/glyph_range_lookup_lru_cache.sv @@
// Sequence: after a lookup request is accepted it passes the match, calc and commit
// states before m_tvalid rises; a load request skips the calc state.
// Requests: one request at a time; a new request is accepted only after the
// current one has passed the match, multiply and commit steps through the
// shared datapath. A stalled result holds the commit of the next request.
// Reset (aresetn low, synchronous) clears config, cache slots and age counter;
// the range table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// glyph_range_lookup_lru_cache
// Range table lookup of a codepoint followed by an LRU glyph cache search.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_range_lookup_lru_cache
    import grl_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // request channel
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // tuser: command (0 lookup, 1 load)
    input  wire logic                s_tuser,
    // tdata: range_index[3:0], range_first[24:4], range_last[45:25],
    //        range_offset[77:46], range_glyph_bytes[83:78], codepoint[104:84]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // configuration: index 0 range_count, index 1 font_valid
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data,
    // result channel
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // tdata: found[0], cache_hit[1], slot[4:2], fetch_address[36:5],
    //        glyph_bytes[42:37]
    output logic [M_DATA_W-1:0]      m_tdata
);

    cmd_t    cmd;
    status_t status;

    // sequencer: one request in flight
    grl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // table, slots, address math and result register
    grl_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

@@ rtl/core/grl_checker.sv @@
// ----------------------------------------------------------------------------
// grl_checker
// Port-level checks of the glyph lookup block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module grl_checker
    import grl_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    // one request at a time: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // a result not found carries all zero fields
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[42:1] == '0)
        else $error("not found result has nonzero fields");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped");

    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind glyph_range_lookup_lru_cache grl_checker u_grl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
